### rtl/awl_pkg.sv
// awl_pkg: shared constants, types and the MAC step decoder for affine_world_to_local.
// Used by the channel interfaces, the controller and the datapath. It has no dependencies.
package awl_pkg;

  // Element format and sizes
  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int NELEM      = 12;
  localparam int IDX_W      = 4;
  localparam int CMD_W      = 2;
  localparam int ADJ_N      = 9;
  localparam int ADJ_IDX_W  = $clog2(ADJ_N);

  // Datapath widths
  localparam int A_W      = 2 * DATA_WIDTH + 1;         // signed adjugate entry
  localparam int AMAG_W   = 2 * DATA_WIDTH;             // |A|, two limbs
  localparam int LIMB_W   = DATA_WIDTH;
  localparam int B_W      = DATA_WIDTH + 1;             // signed B and |B|
  localparam int PROD_W   = LIMB_W + B_W;
  localparam int ACC_W    = 3 * DATA_WIDTH + 8;
  localparam int DS_W     = ACC_W + DATA_WIDTH + 1;
  localparam int QW       = DATA_WIDTH + 2;
  localparam int DIV_CNT_W = $clog2(QW);

  // MAC step program: 18 adjugate terms, 3 determinant terms, 36 numerator terms
  localparam int STEP_W      = 6;
  localparam int N_ADJ_STEPS = 18;
  localparam int NUM_BASE    = 21;
  localparam int N_STEPS     = 57;

  // Singular threshold: |det| <= 2^-40 in Q(3*FRAC_BITS)
  localparam int  SING_SH  = (3 * FRAC_BITS >= 40) ? (3 * FRAC_BITS - 40) : 0;
  localparam logic [ACC_W-1:0] SING_THR =
      (3 * FRAC_BITS >= 40) ? (ACC_W'(1) << SING_SH) : '0;

  // Saturation bounds on the quotient magnitude
  localparam logic [QW-1:0] Q_MAX_POS = QW'((65'd1 << (DATA_WIDTH - 1)) - 65'd1);
  localparam logic [QW-1:0] Q_MAX_NEG = QW'(65'd1 << (DATA_WIDTH - 1));

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_PARENT = 2'd0,
    CMD_LOAD_WORLD  = 2'd1,
    CMD_START       = 2'd2
  } cmd_e;

  typedef enum logic {
    A_PARENT,
    A_ADJ
  } a_sel_e;

  typedef enum logic [1:0] {
    B_PARENT,
    B_WORLD,
    B_TDIFF
  } b_sel_e;

  typedef enum logic [1:0] {
    K_ADJ,
    K_DET,
    K_NUM
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_OPND,
    ST_MLO,
    ST_MHI,
    ST_MACC,
    ST_WB,
    ST_CHK,
    ST_DIV,
    ST_EMIT
  } state_e;

  // One multiply-accumulate term
  typedef struct packed {
    logic [IDX_W-1:0]     pa_addr;
    logic [IDX_W-1:0]     pb_addr;
    logic [IDX_W-1:0]     w_addr;
    logic [ADJ_IDX_W-1:0] adj_idx;
    a_sel_e               a_sel;
    b_sel_e               b_sel;
    logic                 neg;
    logic                 first;
    logic                 last;
    kind_e                kind;
  } op_t;

  // Controller to datapath
  typedef struct packed {
    logic             ld_parent;
    logic             ld_world;
    logic             rd_en;
    logic             opnd_ld;
    logic             mul_lo;
    logic             mul_hi;
    logic             acc_hi;
    logic             wb_adj;
    logic             wb_det;
    logic             div_init;
    logic             div_step;
    logic             out_load;
    logic             out_sing;
    logic             out_last;
    logic [IDX_W-1:0] out_index;
    op_t              op;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic singular;
    logic out_free;
  } dp_stat_t;

  // Decode a step number into its operands
  function automatic op_t op_decode(logic [STEP_W-1:0] s);
    int  si, j, t, r, k, e;
    op_t o;
    si = int'(s);
    o.pa_addr = '0;
    o.pb_addr = '0;
    o.w_addr  = '0;
    o.adj_idx = '0;
    o.a_sel   = A_PARENT;
    o.b_sel   = B_PARENT;
    o.neg     = 1'b0;
    o.first   = 1'b0;
    o.last    = 1'b0;
    o.kind    = K_ADJ;
    if (si < N_ADJ_STEPS) begin
      // adj[r][k] = a[k+1][r+1]*a[k+2][r+2] - a[k+1][r+2]*a[k+2][r+1]
      j = si / 2;
      t = si % 2;
      r = j / 3;
      k = j % 3;
      o.kind    = K_ADJ;
      o.adj_idx = ADJ_IDX_W'(j);
      o.first   = (t == 0);
      o.last    = (t == 1);
      if (t == 0) begin
        o.pa_addr = IDX_W'(((r + 1) % 3) * 3 + (k + 1) % 3);
        o.pb_addr = IDX_W'(((r + 2) % 3) * 3 + (k + 2) % 3);
        o.neg     = 1'b0;
      end else begin
        o.pa_addr = IDX_W'(((r + 2) % 3) * 3 + (k + 1) % 3);
        o.pb_addr = IDX_W'(((r + 1) % 3) * 3 + (k + 2) % 3);
        o.neg     = 1'b1;
      end
    end else if (si < NUM_BASE) begin
      // det = sum a[0][k] * adj[k][0]
      k = si - N_ADJ_STEPS;
      o.kind    = K_DET;
      o.a_sel   = A_ADJ;
      o.adj_idx = ADJ_IDX_W'(k * 3);
      o.pb_addr = IDX_W'(k * 3);
      o.first   = (k == 0);
      o.last    = (k == 2);
    end else if (si < N_STEPS) begin
      e = (si - NUM_BASE) / 3;
      k = (si - NUM_BASE) % 3;
      r = (e < 9) ? (e % 3) : (e - 9);
      o.kind    = K_NUM;
      o.a_sel   = A_ADJ;
      o.adj_idx = ADJ_IDX_W'(r * 3 + k);
      o.first   = (k == 0);
      o.last    = (k == 2);
      if (e < 9) begin
        o.b_sel  = B_WORLD;
        o.w_addr = IDX_W'((e / 3) * 3 + k);
      end else begin
        o.b_sel   = B_TDIFF;
        o.w_addr  = IDX_W'(9 + k);
        o.pb_addr = IDX_W'(9 + k);
      end
    end
    return o;
  endfunction

endpackage

### rtl/awl_in_if.sv
// awl_in_if: input channel (command, element index and value) with valid/ready.
// Depends on awl_pkg.
interface awl_in_if;
  logic                               valid;
  logic                               ready;
  logic [awl_pkg::CMD_W-1:0]          command;
  logic [awl_pkg::IDX_W-1:0]          element_index;
  logic signed [awl_pkg::DATA_WIDTH-1:0] element_value;

  modport source (output valid, command, element_index, element_value, input ready);
  modport sink   (input valid, command, element_index, element_value, output ready);
endinterface

### rtl/awl_out_if.sv
// awl_out_if: result channel (local element, singular and last flags) with valid/ready.
// Depends on awl_pkg.
interface awl_out_if;
  logic                               valid;
  logic                               ready;
  logic [awl_pkg::IDX_W-1:0]          result_index;
  logic signed [awl_pkg::DATA_WIDTH-1:0] result_value;
  logic                               singular;
  logic                               last_result;

  modport source (output valid, result_index, result_value, singular, last_result,
                  input ready);
  modport sink   (input valid, result_index, result_value, singular, last_result,
                  output ready);
endinterface

### rtl/awl_ctrl.sv
// awl_ctrl: sequencer that walks the MAC program, the divider and the result emission.
// Depends on awl_pkg.
module awl_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic [awl_pkg::CMD_W-1:0]  in_command_i,
  input  logic [awl_pkg::IDX_W-1:0]  in_index_i,
  output logic                       in_ready_o,
  input  awl_pkg::dp_stat_t          stat_i,
  output awl_pkg::dp_cmd_t           cmd_o
);

  awl_pkg::state_e                      state_q, state_d;
  logic [awl_pkg::STEP_W-1:0]           step_q, step_d;
  logic [awl_pkg::IDX_W-1:0]            elem_q, elem_d;
  logic [awl_pkg::DIV_CNT_W-1:0]        div_cnt_q, div_cnt_d;
  logic                                 sing_q, sing_d;
  awl_pkg::op_t                         op;
  awl_pkg::op_t                         op_rom [2**awl_pkg::STEP_W];
  logic                                 idx_ok;
  logic                                 elem_last;

  // Step program as a constant table, one entry per step number
  for (genvar g = 0; g < 2**awl_pkg::STEP_W; g++) begin : g_op_rom
    assign op_rom[g] = awl_pkg::op_decode(awl_pkg::STEP_W'(g));
  end

  assign op        = op_rom[step_q];
  assign idx_ok    = (in_index_i < awl_pkg::IDX_W'(awl_pkg::NELEM));
  assign elem_last = (elem_q == awl_pkg::IDX_W'(awl_pkg::NELEM - 1));

  // State and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= awl_pkg::ST_IDLE;
      step_q    <= '0;
      elem_q    <= '0;
      div_cnt_q <= '0;
      sing_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      step_q    <= step_d;
      elem_q    <= elem_d;
      div_cnt_q <= div_cnt_d;
      sing_q    <= sing_d;
    end
  end

  // Next state
  always_comb begin
    state_d   = state_q;
    step_d    = step_q;
    elem_d    = elem_q;
    div_cnt_d = div_cnt_q;
    sing_d    = sing_q;
    case (state_q)
      awl_pkg::ST_IDLE: begin
        if (in_valid_i && (in_command_i == awl_pkg::CMD_START)) begin
          step_d  = '0;
          elem_d  = '0;
          sing_d  = 1'b0;
          state_d = awl_pkg::ST_READ;
        end
      end
      awl_pkg::ST_READ: state_d = awl_pkg::ST_OPND;
      awl_pkg::ST_OPND: state_d = awl_pkg::ST_MLO;
      awl_pkg::ST_MLO:  state_d = awl_pkg::ST_MHI;
      awl_pkg::ST_MHI:  state_d = awl_pkg::ST_MACC;
      awl_pkg::ST_MACC: begin
        if (op.last) begin
          state_d = awl_pkg::ST_WB;
        end else begin
          step_d  = step_q + 1'b1;
          state_d = awl_pkg::ST_READ;
        end
      end
      awl_pkg::ST_WB: begin
        case (op.kind)
          awl_pkg::K_ADJ: begin
            step_d  = step_q + 1'b1;
            state_d = awl_pkg::ST_READ;
          end
          awl_pkg::K_DET: begin
            step_d  = step_q + 1'b1;
            state_d = awl_pkg::ST_CHK;
          end
          default: begin
            div_cnt_d = '0;
            state_d   = awl_pkg::ST_DIV;
          end
        endcase
      end
      awl_pkg::ST_CHK: begin
        if (stat_i.singular) begin
          sing_d  = 1'b1;
          state_d = awl_pkg::ST_EMIT;
        end else begin
          state_d = awl_pkg::ST_READ;
        end
      end
      awl_pkg::ST_DIV: begin
        if (div_cnt_q == awl_pkg::DIV_CNT_W'(awl_pkg::QW - 1)) begin
          state_d = awl_pkg::ST_EMIT;
        end else begin
          div_cnt_d = div_cnt_q + 1'b1;
        end
      end
      awl_pkg::ST_EMIT: begin
        if (stat_i.out_free) begin
          if (sing_q || elem_last) begin
            state_d = awl_pkg::ST_IDLE;
          end else begin
            step_d  = step_q + 1'b1;
            elem_d  = elem_q + 1'b1;
            state_d = awl_pkg::ST_READ;
          end
        end
      end
      default: state_d = awl_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready_o      = (state_q == awl_pkg::ST_IDLE);
    cmd_o           = '0;
    cmd_o.op        = op;
    cmd_o.out_sing  = sing_q;
    cmd_o.out_last  = sing_q || elem_last;
    cmd_o.out_index = sing_q ? '0 : elem_q;
    case (state_q)
      awl_pkg::ST_IDLE: begin
        cmd_o.ld_parent = in_valid_i && idx_ok &&
                          (in_command_i == awl_pkg::CMD_LOAD_PARENT);
        cmd_o.ld_world  = in_valid_i && idx_ok &&
                          (in_command_i == awl_pkg::CMD_LOAD_WORLD);
      end
      awl_pkg::ST_READ: cmd_o.rd_en   = 1'b1;
      awl_pkg::ST_OPND: cmd_o.opnd_ld = 1'b1;
      awl_pkg::ST_MLO:  cmd_o.mul_lo  = 1'b1;
      awl_pkg::ST_MHI:  cmd_o.mul_hi  = 1'b1;
      awl_pkg::ST_MACC: cmd_o.acc_hi  = 1'b1;
      awl_pkg::ST_WB: begin
        cmd_o.wb_adj   = (op.kind == awl_pkg::K_ADJ);
        cmd_o.wb_det   = (op.kind == awl_pkg::K_DET);
        cmd_o.div_init = (op.kind == awl_pkg::K_NUM);
      end
      awl_pkg::ST_DIV:  cmd_o.div_step = 1'b1;
      awl_pkg::ST_EMIT: cmd_o.out_load = stat_i.out_free;
      default: ;
    endcase
  end

endmodule

### rtl/awl_dp.sv
// awl_dp: element stores, shared 32x33 multiplier with accumulator, adjugate registers,
// restoring divider and the result register. Depends on awl_pkg and awl_out_if.
module awl_dp (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic [awl_pkg::IDX_W-1:0]             in_index_i,
  input  logic [awl_pkg::DATA_WIDTH-1:0]        in_value_i,
  input  awl_pkg::dp_cmd_t                      cmd_i,
  output awl_pkg::dp_stat_t                     stat_o,
  awl_out_if.source                             out_o
);

  localparam int DW = awl_pkg::DATA_WIDTH;

  // Stores and their registered read data
  logic [DW-1:0] parent_mem [awl_pkg::NELEM];
  logic [DW-1:0] world_mem  [awl_pkg::NELEM];
  logic [DW-1:0] pa_q, pb_q, w_q;

  // MAC
  logic [awl_pkg::A_W-1:0]    adj_q [awl_pkg::ADJ_N];
  logic [awl_pkg::A_W-1:0]    a_val;
  logic [awl_pkg::B_W-1:0]    b_val;
  logic [awl_pkg::A_W-1:0]    a_abs;
  logic [awl_pkg::B_W-1:0]    b_abs;
  logic [awl_pkg::AMAG_W-1:0] a_mag_q;
  logic [awl_pkg::B_W-1:0]    b_mag_q;
  logic [awl_pkg::LIMB_W-1:0] a_limb;
  logic                       term_neg_q;
  logic [awl_pkg::PROD_W-1:0] prod_q;
  logic [awl_pkg::ACC_W-1:0]  acc_q, addend, acc_sum, acc_abs;

  // Divider
  logic [awl_pkg::ACC_W-1:0]  det_mag_q;
  logic                       det_neg_q;
  logic [awl_pkg::DS_W-1:0]   rem_q, ds_q;
  logic [awl_pkg::QW-1:0]     q_q, q_sat;
  logic                       res_neg_q;
  logic [DW-1:0]              res_val;

  // Result register
  logic                       out_valid_q;
  logic [awl_pkg::IDX_W-1:0]  out_index_q;
  logic [DW-1:0]              out_value_q;
  logic                       out_sing_q;
  logic                       out_last_q;

  // Store writes and reads
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_parent) parent_mem[in_index_i] <= in_value_i;
    if (cmd_i.ld_world)  world_mem[in_index_i]  <= in_value_i;
    if (cmd_i.rd_en) begin
      pa_q <= parent_mem[cmd_i.op.pa_addr];
      pb_q <= parent_mem[cmd_i.op.pb_addr];
      w_q  <= world_mem[cmd_i.op.w_addr];
    end
  end

  // Operand select and magnitude
  always_comb begin
    case (cmd_i.op.a_sel)
      awl_pkg::A_ADJ: a_val = adj_q[cmd_i.op.adj_idx];
      default:        a_val = {{(awl_pkg::A_W - DW){pa_q[DW-1]}}, pa_q};
    endcase
    case (cmd_i.op.b_sel)
      awl_pkg::B_WORLD: b_val = {w_q[DW-1], w_q};
      awl_pkg::B_TDIFF: b_val = {w_q[DW-1], w_q} - {pb_q[DW-1], pb_q};
      default:          b_val = {pb_q[DW-1], pb_q};
    endcase
    a_abs = a_val[awl_pkg::A_W-1] ? (~a_val + 1'b1) : a_val;
    b_abs = b_val[awl_pkg::B_W-1] ? (~b_val + 1'b1) : b_val;
  end

  // Limb of |A| fed to the single multiplier
  assign a_limb = cmd_i.mul_hi ? a_mag_q[awl_pkg::AMAG_W-1:awl_pkg::LIMB_W]
                               : a_mag_q[awl_pkg::LIMB_W-1:0];

  // Accumulate one partial product, low limb unshifted, high limb shifted by a limb
  assign addend  = cmd_i.acc_hi ? (awl_pkg::ACC_W'(prod_q) << awl_pkg::LIMB_W)
                                : awl_pkg::ACC_W'(prod_q);
  assign acc_sum = term_neg_q ? (acc_q - addend) : (acc_q + addend);
  assign acc_abs = acc_q[awl_pkg::ACC_W-1] ? (~acc_q + 1'b1) : acc_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.opnd_ld) begin
      a_mag_q    <= a_abs[awl_pkg::AMAG_W-1:0];
      b_mag_q    <= b_abs;
      term_neg_q <= a_val[awl_pkg::A_W-1] ^ b_val[awl_pkg::B_W-1] ^ cmd_i.op.neg;
      if (cmd_i.op.first) acc_q <= '0;
    end
    if (cmd_i.mul_lo || cmd_i.mul_hi) begin
      prod_q <= {{awl_pkg::B_W{1'b0}}, a_limb} * {{awl_pkg::LIMB_W{1'b0}}, b_mag_q};
    end
    if (cmd_i.mul_hi) acc_q <= acc_sum;
    if (cmd_i.acc_hi) acc_q <= acc_sum;
    if (cmd_i.wb_adj) adj_q[cmd_i.op.adj_idx] <= acc_q[awl_pkg::A_W-1:0];
    if (cmd_i.wb_det) begin
      det_neg_q <= acc_q[awl_pkg::ACC_W-1];
      det_mag_q <= acc_abs;
    end
  end

  // Restoring divider: |num| * 2^FRAC_BITS / |det|, one quotient bit a cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      rem_q     <= awl_pkg::DS_W'({acc_abs, {awl_pkg::FRAC_BITS{1'b0}}});
      ds_q      <= awl_pkg::DS_W'(det_mag_q) << (DW + 1);
      q_q       <= '0;
      res_neg_q <= acc_q[awl_pkg::ACC_W-1] ^ det_neg_q;
    end else if (cmd_i.div_step) begin
      if (rem_q >= ds_q) begin
        rem_q <= rem_q - ds_q;
        q_q   <= {q_q[awl_pkg::QW-2:0], 1'b1};
      end else begin
        q_q   <= {q_q[awl_pkg::QW-2:0], 1'b0};
      end
      ds_q <= ds_q >> 1;
    end
  end

  // Saturate and apply sign
  always_comb begin
    if (res_neg_q) q_sat = (q_q > awl_pkg::Q_MAX_NEG) ? awl_pkg::Q_MAX_NEG : q_q;
    else           q_sat = (q_q > awl_pkg::Q_MAX_POS) ? awl_pkg::Q_MAX_POS : q_q;
    res_val = res_neg_q ? (~q_sat[DW-1:0] + 1'b1) : q_sat[DW-1:0];
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_index_q <= cmd_i.out_index;
      out_value_q <= cmd_i.out_sing ? '0 : res_val;
      out_sing_q  <= cmd_i.out_sing;
      out_last_q  <= cmd_i.out_last;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.result_index = out_index_q;
  assign out_o.result_value = out_value_q;
  assign out_o.singular     = out_sing_q;
  assign out_o.last_result  = out_last_q;

  assign stat_o.singular = (det_mag_q <= awl_pkg::SING_THR);
  assign stat_o.out_free = !out_valid_q || out_o.ready;

endmodule

### rtl/affine_world_to_local.sv
// affine_world_to_local: top level, local = inverse(parent) * world for 3x4 affine transforms.
// Depends on awl_pkg, awl_in_if, awl_out_if, awl_ctrl and awl_dp.
//
// Usage: the in_i channel takes one item per accepted handshake. Command load parent
// or load world writes one Q16.16 element (index 0-8 rotation column-major, 9-11
// translation); element indexes 12-15 and the unused command are dropped.
// Command start runs the compute; no item is accepted until the run is finished.
// The out_o channel then delivers 12 items, index 0..11, the last one flagged, or a
// single item flagged singular when |det(parent rotation)| <= 2^-40.
// Each multiply-accumulate term runs on the shared 32x33 multiplier as store read, operand
// magnitude, low limb, high limb and final add. The adjugate takes 18 terms, the determinant
// 3, each result 3 terms plus a restoring divide. A singular verdict follows the determinant.
// The result sits in an output register: while out_o is stalled the next result is
// still computed, and the sequencer waits only when that register is still full.
// Reset clears the sequencer and the output valid; the element stores hold no reset
// value and must be loaded before a start.
module affine_world_to_local (
  input  logic       clk_i,
  input  logic       rst_ni,
  awl_in_if.sink     in_i,
  awl_out_if.source  out_o
);

  awl_pkg::dp_cmd_t  dp_cmd;
  awl_pkg::dp_stat_t dp_stat;

  awl_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_command_i (in_i.command),
    .in_index_i   (in_i.element_index),
    .in_ready_o   (in_i.ready),
    .stat_i       (dp_stat),
    .cmd_o        (dp_cmd)
  );

  awl_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_index_i (in_i.element_index),
    .in_value_i (in_i.element_value),
    .cmd_i      (dp_cmd),
    .stat_o     (dp_stat),
    .out_o      (out_o)
  );

endmodule
